>>> hw/rtl/csr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_pkg: shared types and constants of the cubic spline resampler
// Sample and position formats, arithmetic widths, and the opcodes of the
// fraction multiply unit.
// ----------------------------------------------------------------------------
package csr_pkg;

  localparam int SAMPLE_BITS = 32;   // significant bits of a sample, 16..32
  localparam int MAX_OUTPUTS = 64;   // result limit per input item, 1..64

  localparam int SMP_W  = 32;        // sample port width
  localparam int STEP_W = 39;        // step register, unsigned 7.32
  localparam int POS_W  = 40;        // read position, 8.32
  localparam int FRAC_W = 32;        // fraction of the position
  localparam int HALF_W = FRAC_W / 2;
  localparam int T_W    = 40;        // Horner term, holds 6a, 6b, 6c and partials
  localparam int PROD_W = T_W + HALF_W + 1;
  localparam int ACC_W  = T_W + FRAC_W;
  localparam int CNT_W  = $clog2(MAX_OUTPUTS + 1);

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(64'h1_0000_0000);

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic signed [T_W-1:0]   term_t;

  typedef enum logic [1:0] {
    MAC_HOLD = 2'd0,
    MAC_LO   = 2'd1,
    MAC_HI   = 2'd2
  } mac_op_t;

endpackage

>>> hw/rtl/csr_frac_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_frac_mac: shared fraction multiply-accumulate unit
// Forms round(t * f / 2^32) + addend over two 40x17 multiplies, one per
// 16-bit half of the fraction, with the product registered before the add.
// ----------------------------------------------------------------------------
module csr_frac_mac (
  input  logic                          clk,
  input  csr_pkg::mac_op_t              op,
  input  csr_pkg::term_t                opnd,
  input  logic [csr_pkg::FRAC_W-1:0]    frac,
  input  csr_pkg::term_t                addend,
  output csr_pkg::term_t                result
);
  import csr_pkg::*;

  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_W - 1);

  logic        [HALF_W:0]   chunk;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  sum;

  always_comb begin
    if (op == MAC_HI) begin
      chunk = {1'b0, frac[FRAC_W-1:HALF_W]};
    end else begin
      chunk = {1'b0, frac[HALF_W-1:0]};
    end
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    case (op)
      MAC_LO: begin
        prod_nxt = PROD_W'(opnd) * PROD_W'($signed(chunk));
      end
      MAC_HI: begin
        prod_nxt = PROD_W'(opnd) * PROD_W'($signed(chunk));
        // low partial product, rounding bias and addend, all in 32.32 units
        acc_nxt  = ACC_W'(prod_r) + ROUND_BIAS + (ACC_W'(addend) <<< FRAC_W);
      end
      default: begin
      end
    endcase
    sum    = acc_r + (ACC_W'(prod_r) <<< HALF_W);
    result = sum[ACC_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

endmodule

>>> hw/rtl/cubic_spline_resampler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_spline_resampler_top: cubic interpolating sample rate converter
// Four-sample window, 8.32 read position, one shared multiply unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one signed sample per item (valid/ready). in_ready is high only
//            while the sequencer waits for a new item.
//   out_*  : interpolated samples (valid/ready); out_last_of_run marks the
//            final result caused by an input item. A one-item output
//            register parts the channels, so the next input is taken while
//            the last result of a run still waits.
//   cfg_*  : step_size write (valid/ready, always ready); write it only
//            while the block is idle.
// Sequence: an item that only fills the window or causes no result leaves
//   the sequencer waiting. An item with N results (N up to 64) first forms
//   6a, 6b, 6c in S_COEF1 and S_COEF2, then each result passes through the
//   shared 40x17 multiplier (three fraction multiplies of two halves each),
//   the divide by three (8 quotient bits a cycle) and saturation and hand-off.
// Reset: window cleared, position zero, step 1.0; the first two items only
//   fill the window. A stalled receiver holds the sequencer in its hand-off
//   state; the output item holds until taken.
// ----------------------------------------------------------------------------
module cubic_spline_resampler_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [csr_pkg::SMP_W-1:0] in_sample_in,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [csr_pkg::SMP_W-1:0] out_sample_out,
  output logic                          out_last_of_run,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [csr_pkg::STEP_W-1:0]    cfg_step_size
);
  import csr_pkg::*;

  localparam int INT_W = POS_W - FRAC_W;
  localparam logic [POS_W-1:0] ONE_POS = POS_W'(1) << FRAC_W;
  localparam logic [1:0] FILL_LAST = 2'd2;
  localparam logic [1:0] FILL_FULL = 2'd3;
  localparam logic [1:0] PASS_A = 2'd0;   // t = a*x + b
  localparam logic [1:0] PASS_B = 2'd1;   // t = t*x + c
  localparam logic [1:0] PASS_C = 2'd2;   // t = t*x
  localparam int DIV_W     = T_W;
  localparam int DIV_DIGIT = 8;
  localparam int DIV_STEPS = DIV_W / DIV_DIGIT;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam logic [2:0] DIVISOR = 3'd3;
  localparam logic signed [T_W:0] DIV_OFFSET = (T_W + 1)'(3) <<< (T_W - 2);
  localparam logic signed [T_W:0] Q_OFFSET   = (T_W + 1)'(1) <<< (T_W - 2);
  localparam logic signed [T_W:0] SAT_HI =
    (T_W + 1)'((longint'(1) <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [T_W:0] SAT_LO = -SAT_HI - (T_W + 1)'(1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_COEF1 = 10'b00_0000_0010,
    S_COEF2 = 10'b00_0000_0100,
    S_MLO   = 10'b00_0000_1000,
    S_MHI   = 10'b00_0001_0000,
    S_MACC  = 10'b00_0010_0000,
    S_DPREP = 10'b00_0100_0000,
    S_DIV   = 10'b00_1000_0000,
    S_FIN   = 10'b01_0000_0000,
    S_EMIT  = 10'b10_0000_0000
  } state_t;

  // control state
  state_t              state_r, state_nxt;
  logic [1:0]          fill_r, fill_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [1:0]          pass_r, pass_nxt;
  logic [DCNT_W-1:0]   dcnt_r, dcnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  smp_t                window_r [4];
  smp_t                window_nxt [4];

  // datapath
  term_t               b2_r, b2_nxt, d_r, d_nxt, e_r, e_nxt;
  term_t               a6_r, a6_nxt, b3_r, b3_nxt, c6_r, c6_nxt;
  term_t               t_r, t_nxt;
  logic [DIV_W-1:0]    u_r, u_nxt, q_r, q_nxt;
  logic [1:0]          rem_r, rem_nxt;
  smp_t                res_r, res_nxt;
  smp_t                out_sample_r, out_sample_nxt;
  logic                out_last_r, out_last_nxt;

  // helpers
  smp_t                smp_in;
  logic [POS_W-1:0]    pos_dec, pos_chk, pos_add;
  logic                last_hit, out_load;
  mac_op_t             mac_op;
  term_t               addend, mac_result, a6_c;
  logic signed [T_W:0] w_s, u_s, r_full, r_sat;
  logic [1:0]          rem_v;
  logic [2:0]          r3_v;
  logic [DIV_W-1:0]    q_v;

  assign in_ready        = (state_r == S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_last_of_run = out_last_r;

  // take the low SAMPLE_BITS bits and sign-extend
  assign smp_in = SMP_W'(signed'(in_sample_in[SAMPLE_BITS-1:0]));

  csr_frac_mac u_mac (
    .clk    (clk),
    .op     (mac_op),
    .opnd   (t_r),
    .frac   (pos_r[FRAC_W-1:0]),
    .addend (addend),
    .result (mac_result)
  );

  // divide by three, one quotient byte per cycle
  always_comb begin
    rem_v = rem_r;
    q_v   = q_r;
    r3_v  = '0;
    for (int i = 0; i < DIV_DIGIT; i++) begin
      r3_v = {rem_v, u_r[DIV_W-1-i]};
      if (r3_v >= DIVISOR) begin
        rem_v = 2'(r3_v - DIVISOR);
        q_v   = {q_v[DIV_W-2:0], 1'b1};
      end else begin
        rem_v = r3_v[1:0];
        q_v   = {q_v[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    // defaults: hold
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    pos_nxt        = pos_r;
    step_nxt       = step_r;
    n_nxt          = n_r;
    pass_nxt       = pass_r;
    dcnt_nxt       = dcnt_r;
    window_nxt     = window_r;
    b2_nxt         = b2_r;
    d_nxt          = d_r;
    e_nxt          = e_r;
    a6_nxt         = a6_r;
    b3_nxt         = b3_r;
    c6_nxt         = c6_r;
    t_nxt          = t_r;
    u_nxt          = u_r;
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    res_nxt        = res_r;
    mac_op         = MAC_HOLD;
    out_load       = 1'b0;

    if (cfg_valid && cfg_ready) begin
      step_nxt = cfg_step_size;
    end

    // position decrement for a new item and advance after a result
    if (pos_r[POS_W-1:FRAC_W] != '0) begin
      pos_dec = pos_r - ONE_POS;
    end else begin
      pos_dec = pos_r;
    end
    pos_chk  = (fill_r == FILL_FULL) ? pos_dec : pos_r;
    pos_add  = pos_r + POS_W'(step_r);
    last_hit = (pos_add[POS_W-1:FRAC_W] != '0) || (n_r == CNT_W'(MAX_OUTPUTS - 1));

    // Horner addend of the current pass
    case (pass_r)
      PASS_A:  addend = b3_r;
      PASS_B:  addend = c6_r;
      default: addend = '0;
    endcase

    a6_c = d_r - (b2_r <<< 1);

    // final scaling: floor((t + 3) / 6) made unsigned before the divide
    w_s = (T_W + 1)'(t_r) + (T_W + 1)'(3);
    u_s = (w_s >>> 1) + DIV_OFFSET;

    r_full = (T_W + 1)'($signed({1'b0, q_r})) - Q_OFFSET + (T_W + 1)'(window_r[1]);
    if (r_full > SAT_HI) begin
      r_sat = SAT_HI;
    end else if (r_full < SAT_LO) begin
      r_sat = SAT_LO;
    end else begin
      r_sat = r_full;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          window_nxt[0] = window_r[1];
          window_nxt[1] = window_r[2];
          window_nxt[2] = window_r[3];
          window_nxt[3] = smp_in;
          n_nxt         = '0;
          if (fill_r != FILL_FULL) begin
            fill_nxt = fill_r + 2'd1;
          end else begin
            pos_nxt = pos_dec;
          end
          if ((fill_r == FILL_LAST || fill_r == FILL_FULL) &&
              pos_chk[POS_W-1:FRAC_W] == '0) begin
            state_nxt = S_COEF1;
          end
        end
      end
      S_COEF1: begin
        b2_nxt = T_W'(window_r[2]) + T_W'(window_r[0]) - (T_W'(window_r[1]) <<< 1);
        d_nxt  = T_W'(window_r[3]) - T_W'(window_r[2]) + T_W'(window_r[0])
               - T_W'(window_r[1]);
        e_nxt  = T_W'(window_r[2]) - T_W'(window_r[1]);
        state_nxt = S_COEF2;
      end
      S_COEF2: begin
        a6_nxt    = a6_c;
        b3_nxt    = b2_r + (b2_r <<< 1);
        c6_nxt    = (e_r <<< 2) + (e_r <<< 1) - d_r - b2_r;
        t_nxt     = a6_c;
        pass_nxt  = PASS_A;
        state_nxt = S_MLO;
      end
      S_MLO: begin
        mac_op    = MAC_LO;
        state_nxt = S_MHI;
      end
      S_MHI: begin
        mac_op    = MAC_HI;
        state_nxt = S_MACC;
      end
      S_MACC: begin
        t_nxt = mac_result;
        if (pass_r == PASS_C) begin
          state_nxt = S_DPREP;
        end else begin
          pass_nxt  = pass_r + 2'd1;
          state_nxt = S_MLO;
        end
      end
      S_DPREP: begin
        u_nxt     = u_s[DIV_W-1:0];
        q_nxt     = '0;
        rem_nxt   = '0;
        dcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        u_nxt    = u_r << DIV_DIGIT;
        q_nxt    = q_v;
        rem_nxt  = rem_v;
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        res_nxt   = SMP_W'(r_sat);
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // hand off once the output register is free or being drained
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          pos_nxt  = pos_add;
          n_nxt    = n_r + CNT_W'(1);
          if (last_hit) begin
            // a run cut short by the limit drops the rest of this window
            if (pos_add[POS_W-1:FRAC_W] == '0) begin
              pos_nxt = {INT_W'(1), pos_add[FRAC_W-1:0]};
            end
            state_nxt = S_IDLE;
          end else begin
            t_nxt     = a6_r;
            pass_nxt  = PASS_A;
            state_nxt = S_MLO;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = res_r;
      out_last_nxt   = last_hit;
    end else begin
      out_valid_nxt  = out_ready ? 1'b0 : out_valid_r;
      out_sample_nxt = out_sample_r;
      out_last_nxt   = out_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      pos_r       <= '0;
      step_r      <= STEP_RESET;
      n_r         <= '0;
      pass_r      <= PASS_A;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        window_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      pos_r       <= pos_nxt;
      step_r      <= step_nxt;
      n_r         <= n_nxt;
      pass_r      <= pass_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
      window_r    <= window_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b2_r         <= b2_nxt;
    d_r          <= d_nxt;
    e_r          <= e_nxt;
    a6_r         <= a6_nxt;
    b3_r         <= b3_nxt;
    c6_r         <= c6_nxt;
    t_r          <= t_nxt;
    u_r          <= u_nxt;
    q_r          <= q_nxt;
    rem_r        <= rem_nxt;
    res_r        <= res_nxt;
    out_sample_r <= out_sample_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

>>> hw/rtl/csr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csr_checker: port-level checks of the cubic spline resampler
// Watches the channels of the top level over time; bound to it below.
// ----------------------------------------------------------------------------
module csr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [csr_pkg::SMP_W-1:0] out_sample_out,
  input logic                             out_last_of_run
);

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output item survived reset");

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out) &&
                                $stable(out_last_of_run))
    else $error("stalled output item changed");

  // results are only produced while a run is in progress
  a_out_during_run: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("output item appeared while waiting for input");

  // a run ends by handing off its final item
  a_run_end_marked: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(in_ready) |-> out_valid && out_last_of_run)
    else $error("run ended without a final item");

endmodule

bind cubic_spline_resampler_top csr_checker u_csr_checker (.*);

>>> verif/cubic_spline_resampler_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_spline_resampler_top_test: self-checking bench for the resampler
// Drives samples and step writes over valid/ready, predicts every output of
// the four-tap cubic with its own fixed-point model, and checks the output
// stream in order under random idling and a long receiver hold-off.
// ----------------------------------------------------------------------------
module cubic_spline_resampler_top_test;
  import csr_pkg::*;

  localparam int  HALF_PERIOD   = 1;
  localparam int  RESET_CYCLES  = 9;
  localparam int  IDLE_PERCENT  = 36;
  localparam int  SETTLE_CYCLES = 40;         // covers a no-result item in flight
  localparam int  TOTAL_ITEMS   = 230;        // minimum number of items over the whole run
  localparam int  HOLD_CYCLES   = 400;
  localparam longint LIMIT_NS   = 64'd10_000_000;

  localparam smp_t SAMPLE_MAX = 32'sh7FFF_FFFF;
  localparam smp_t SAMPLE_MIN = 32'sh8000_0000;
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(64'h1_0000_0000);

  // one output item as the block should present it
  typedef struct packed {
    smp_t sample;
    logic last;
  } resampled_t;

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_ready;
  smp_t              in_sample_in    = '0;
  logic              out_valid;
  logic              out_ready       = 1'b0;
  smp_t              out_sample_out;
  logic              out_last_of_run;
  logic              cfg_valid       = 1'b0;
  logic              cfg_ready;
  logic [STEP_W-1:0] cfg_step_size   = '0;

  // interpolator state as the bench expects it to evolve
  longint            window_taps [0:3] = '{0, 0, 0, 0};
  logic [POS_W-1:0]  read_pos    = '0;
  int                taps_filled = 0;
  logic [STEP_W-1:0] step_now    = STEP_RESET;

  resampled_t        awaited_outputs [$];
  int                mismatch_count    = 0;
  int                ready_hold_cycles = 0;
  int                items_sent        = 0;
  bit                idle_on           = 1'b1;
  longint            walk_level        = 0;

  cubic_spline_resampler_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_in    (in_sample_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample_out  (out_sample_out),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_step_size   (cfg_step_size)
  );

  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Fixed-point cubic
  // --------------------------------------------------------------------------

  // round(t * f / 2^32) with halves going up; split f to keep products small
  function automatic longint frac_scale(longint t, logic [FRAC_W-1:0] f);
    longint f_hi;
    longint f_lo;
    longint q;
    f_hi = {48'd0, f[31:16]};
    f_lo = {48'd0, f[15:0]};
    q = t * f_hi + ((t * f_lo) >>> 16);
    return (q + 64'sd32768) >>> 16;
  endfunction

  // divide by six, nearest, halves up
  function automatic longint sixth_nearest(longint v);
    longint w;
    w = v + 3;
    if (w >= 0) return w / 6;
    return -((-w + 5) / 6);
  endfunction

  function automatic smp_t cubic_at(logic [FRAC_W-1:0] f);
    longint sm1, s0, s1, s2;
    longint b2, a6, c6, acc, r, top, bottom;
    sm1 = window_taps[0];
    s0  = window_taps[1];
    s1  = window_taps[2];
    s2  = window_taps[3];
    // scaled coefficients: b2 = 2b, a6 = 6a, c6 = 6c
    b2  = s1 + sm1 - 2 * s0;
    a6  = s2 - s1 + sm1 - s0 - 2 * b2;
    c6  = 6 * (s1 - s0) - a6 - 3 * b2;
    acc = frac_scale(a6, f) + 3 * b2;
    acc = frac_scale(acc, f) + c6;
    acc = frac_scale(acc, f);
    r   = s0 + sixth_nearest(acc);
    top    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    bottom = -top - 1;
    if (r > top) r = top;
    if (r < bottom) r = bottom;
    return smp_t'(r[31:0]);
  endfunction

  // Shift one accepted sample into the window and queue every output it causes.
  function automatic void interpolate_item(smp_t s);
    longint     v;
    int         n;
    resampled_t item;
    v = longint'(s);
    v = (v <<< (64 - SAMPLE_BITS)) >>> (64 - SAMPLE_BITS);
    window_taps[0] = window_taps[1];
    window_taps[1] = window_taps[2];
    window_taps[2] = window_taps[3];
    window_taps[3] = v;

    if (taps_filled < 3) begin
      taps_filled++;
      if (taps_filled < 3) return;   // still filling, nothing comes out
    end else if (read_pos[39:32] != 0) begin
      read_pos = read_pos - POS_ONE;
    end

    n = 0;
    while (read_pos[39:32] == 0 && n < MAX_OUTPUTS) begin
      item.sample = cubic_at(read_pos[31:0]);
      read_pos    = read_pos + POS_W'(step_now);
      n++;
      item.last   = !(read_pos[39:32] == 0 && n < MAX_OUTPUTS);
      awaited_outputs.push_back(item);
    end
    // run cut short at the output limit: drop the rest, keep the fraction
    if (read_pos[39:32] == 0) read_pos[39:32] = 8'd1;
  endfunction

  // mostly a bounded random walk, with some white noise and rail values
  function automatic smp_t next_audio_sample();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      walk_level += longint'($urandom_range(0, 32'h1000_0000)) - 64'sh0800_0000;
      if (walk_level > longint'(SAMPLE_MAX)) walk_level = longint'(SAMPLE_MAX);
      if (walk_level < longint'(SAMPLE_MIN)) walk_level = longint'(SAMPLE_MIN);
      return smp_t'(walk_level[31:0]);
    end
    if (roll < 85) return smp_t'($urandom);
    case ($urandom_range(0, 3))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return smp_t'(0);
      default: return smp_t'(-1);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Channel drivers
  // --------------------------------------------------------------------------

  // Offer one sample; enter and leave on a rising edge.
  task automatic send_sample(input smp_t s);
    while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (!in_ready);
    interpolate_item(s);
    items_sent++;
  endtask

  // Drop valid and wait for every queued output, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the step register only once the block has gone idle.
  task automatic set_step(input logic [STEP_W-1:0] s);
    wait_drained();
    cfg_valid     <= 1'b1;
    cfg_step_size <= s;
    do @(posedge clk); while (!cfg_ready);
    step_now = s;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Feed samples until the position comes back to the current window.
  task automatic skip_to_window();
    while (read_pos[39:32] > 1) send_sample(next_audio_sample());
  endtask

  // --------------------------------------------------------------------------
  // Receiver and output check
  // --------------------------------------------------------------------------

  // Hold ready low for a requested stretch, otherwise idle at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (ready_hold_cycles > 0) begin
      out_ready <= 1'b0;
      ready_hold_cycles--;
    end else begin
      out_ready <= !(idle_on && $urandom_range(0, 99) < IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin : check_outputs
    resampled_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_outputs.size() == 0) begin
        $display("%0t: unexpected item: expected none, got sample %0d last %0b",
                 $time, out_sample_out, out_last_of_run);
        mismatch_count++;
      end else begin
        want = awaited_outputs.pop_front();
        if (out_sample_out !== want.sample) begin
          $display("%0t: sample_out mismatch: expected %0d, got %0d",
                   $time, want.sample, out_sample_out);
          mismatch_count++;
        end
        if (out_last_of_run !== want.last) begin
          $display("%0t: last_of_run mismatch: expected %0b, got %0b",
                   $time, want.last, out_last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset step of 1.0: two items fill the window, then each item yields s0.
  task automatic test_window_fill();
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(smp_t'(0));
    send_sample(smp_t'(-1));
    send_sample(smp_t'(1));
    send_sample(SAMPLE_MAX);
  endtask

  // Rail-to-rail pairs make the cubic overshoot, so the output saturates.
  task automatic test_sample_extremes();
    set_step(STEP_W'(64'h0_5555_5555));
    repeat (2) begin
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MIN);
    end
  endtask

  // A step of 1/64, up to 64 outputs per item, then a zero step and a step just under
  // 1/64, both of which hit the per-item output limit.
  task automatic test_output_limit();
    set_step(STEP_W'(64'h0_0400_0000));
    send_sample(smp_t'(32'h4000_0000));
    send_sample(smp_t'(32'hC000_0000));
    set_step('0);
    send_sample(smp_t'(32'h1234_5678));
    send_sample(smp_t'(32'h8765_4321));
    set_step(STEP_W'(64'h0_03FF_FFFF));
    send_sample(smp_t'(32'h7000_0001));
  endtask

  // Largest legal step and the all-ones step: mostly items with no output.
  task automatic test_step_extremes();
    set_step(STEP_W'(64'h40_0000_0000));
    repeat (3) send_sample(next_audio_sample());
    set_step('1);
    repeat (3) send_sample(next_audio_sample());
    skip_to_window();
  endtask

  // Stall the receiver long enough that the block backs up into its input.
  task automatic test_output_backpressure();
    set_step(STEP_W'(64'h0_8000_0000));
    ready_hold_cycles = HOLD_CYCLES;
    repeat (16) send_sample(next_audio_sample());
  endtask

  // Random phases: a new step each phase, random audio-like content.
  task automatic test_random_resampling();
    int phase;
    int kind;
    int count;
    phase = 0;
    while (phase < 6 || items_sent < TOTAL_ITEMS) begin
      kind    = (phase < 6) ? phase : $urandom_range(0, 5);
      idle_on = (phase != 1);               // one long stretch with no idling
      count   = (phase == 1) ? 20 : 12;
      case (kind)
        0: set_step(STEP_W'($urandom_range(32'h1000_0000, 32'hFFFF_FFFF)));
        1: set_step(STEP_W'(64'h1_0000_0000) + STEP_W'($urandom_range(0, 32'h2000_0000))
                    - STEP_W'(64'h1000_0000));
        2: set_step(STEP_W'({3'($urandom_range(1, 7)), 32'($urandom)}));
        3: begin
          set_step(STEP_W'($urandom_range(32'h0400_0000, 32'h1000_0000)));
          count = 8;                        // up to 64 outputs each, keep it short
        end
        4: set_step(STEP_W'({$urandom, $urandom}));
        default: set_step(STEP_W'({6'($urandom_range(8, 63)), 32'($urandom)}));
      endcase
      repeat (count) send_sample(next_audio_sample());
      if (kind >= 4) skip_to_window();
      phase++;
    end
    idle_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Run
  // --------------------------------------------------------------------------

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_window_fill();
    test_sample_extremes();
    test_output_limit();
    test_step_extremes();
    test_output_backpressure();
    test_random_resampling();
    wait_drained();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop in case the output stream hangs.
  initial begin
    #(LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/csr_pkg.sv
hw/rtl/csr_frac_mac.sv
hw/rtl/cubic_spline_resampler_top.sv
hw/rtl/csr_checker.sv
verif/cubic_spline_resampler_top_test.sv
